>>> hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants of the bitmap page allocator
// Map geometry, operation and status codes, and the lowest-set-bit search.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  localparam int unsigned BlockCount  = 65536;
  localparam int unsigned BlockShift  = 12;
  localparam int unsigned WordBits    = 32;
  localparam int unsigned MapWords    = BlockCount / WordBits;
  localparam int unsigned WordIdxW    = $clog2(MapWords);
  localparam int unsigned BitIdxW     = $clog2(WordBits);
  localparam int unsigned BlkIdxW     = $clog2(BlockCount);
  localparam int unsigned BlkCntW     = BlkIdxW + 1;
  localparam int unsigned AddrW       = 28;
  localparam int unsigned LenW        = 29;
  localparam int unsigned CfgW        = 17;
  localparam int unsigned FuncW       = 2;
  localparam int unsigned StatusW     = 2;

  localparam logic [CfgW-1:0] ReservedReset = CfgW'(32'h0040_0000 >> BlockShift);

  typedef enum logic [FuncW-1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_RELEASE = 2'd2
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_OOM   = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    CFG_TOTAL    = 1'b0,
    CFG_RESERVED = 1'b1
  } cfg_idx_e;

  function automatic logic [BitIdxW-1:0] lowest_set(input logic [WordBits-1:0] v);
    logic [BitIdxW-1:0] idx;
    idx = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BitIdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator: first-fit page-frame allocator over a used-block map
// Allocate, free and region release on a bitmap of 4 KiB blocks.
// ----------------------------------------------------------------------------
// After reset busy_o stays high while every map RAM word is filled with
// ones (every block used); configuration writes are taken meanwhile.
// One shared word unit reads a map word, masks it and either finds its lowest
// free bit or clears a bit range, then writes it back, in states S_RD and
// S_MOD, through the single-port-read RAM. Allocate scans map words from the
// first (up to 2048 with 65536 blocks), free handles one word, region release
// each map word covered; each result appears on done_o in the cycle after its
// last map word is handled, for exactly one cycle, and cannot be held off.
// Out-of-range frees, releases that cover no clearable block, unused codes
// and allocation with no managed blocks answer in the cycle after the
// transfer. start_i is taken when busy_o is low, also while done_o is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_allocator (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [bpa_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire logic                        start_i,
  input  wire logic [bpa_pkg::FuncW-1:0]   func_i,
  input  wire logic [bpa_pkg::AddrW-1:0]   addr_i,
  input  wire logic [bpa_pkg::LenW-1:0]    length_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic      [bpa_pkg::AddrW-1:0]   block_addr_o,
  output logic      [bpa_pkg::StatusW-1:0] status_o
);

  import bpa_pkg::*;

  typedef enum logic [3:0] {
    S_INIT = 4'b0001,
    S_IDLE = 4'b0010,
    S_RD   = 4'b0100,
    S_MOD  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  func_e              op_q, op_d;
  logic [WordIdxW-1:0] ptr_q, ptr_d;
  logic [WordIdxW-1:0] last_q, last_d;
  logic [BitIdxW-1:0]  lo_q, lo_d;
  logic [BitIdxW-1:0]  hi_q, hi_d;
  logic                done_q, done_d;
  logic [AddrW-1:0]    baddr_q, baddr_d;
  status_e             status_q, status_d;
  logic [CfgW-1:0]     total_q, rsv_q;

  logic [BlkCntW-1:0]  lim;
  logic [BlkCntW-1:0]  lim_m1;
  logic [BlkIdxW-1:0]  start_blk;
  logic [BlkCntW:0]    end_sum;
  logic [BlkCntW-1:0]  end_blk;
  logic [BlkCntW-1:0]  end_m1;
  logic [BlkCntW-1:0]  lo_eff;

  logic                we;
  logic [WordBits-1:0] wdata;
  logic                re;
  logic [WordBits-1:0] rdata;

  logic [WordBits-1:0] range_mask;
  logic [WordBits-1:0] avail;
  logic [BitIdxW-1:0]  hit_bit;

  assign lim       = (total_q < CfgW'(BlockCount)) ? BlkCntW'(total_q) : BlkCntW'(BlockCount);
  assign lim_m1    = lim - BlkCntW'(1);
  assign start_blk = addr_i[AddrW-1:BlockShift];
  assign end_sum   = (BlkCntW+1)'(start_blk) + (BlkCntW+1)'(length_i[LenW-1:BlockShift]);
  assign end_blk   = (end_sum > (BlkCntW+1)'(BlockCount)) ? BlkCntW'(BlockCount)
                                                          : BlkCntW'(end_sum);
  assign end_m1    = end_blk - BlkCntW'(1);
  assign lo_eff    = (BlkCntW'(rsv_q) > BlkCntW'(start_blk)) ? BlkCntW'(rsv_q)
                                                             : BlkCntW'(start_blk);

  assign range_mask = ({WordBits{1'b1}} << lo_q) &
                      ((ptr_q == last_q) ? ({WordBits{1'b1}} >> (BitIdxW'(WordBits - 1) - hi_q))
                                         : {WordBits{1'b1}});
  assign avail      = ~rdata & range_mask;
  assign hit_bit    = lowest_set(avail);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    ptr_d    = ptr_q;
    last_d   = last_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    done_d   = 1'b0;
    baddr_d  = baddr_q;
    status_d = status_q;
    we       = 1'b0;
    wdata    = {WordBits{1'b1}};
    re       = 1'b0;

    case (state_q)
      S_INIT: begin
        we    = 1'b1;
        ptr_d = ptr_q + WordIdxW'(1);
        if (ptr_q == WordIdxW'(MapWords - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          baddr_d  = '0;
          status_d = STAT_OK;
          op_d     = func_e'(func_i);
          case (func_i)
            FUNC_ALLOC: begin
              if (lim == '0) begin
                done_d   = 1'b1;
                status_d = STAT_OOM;
              end else begin
                ptr_d   = '0;
                last_d  = lim_m1[BlkIdxW-1:BitIdxW];
                lo_d    = '0;
                hi_d    = lim_m1[BitIdxW-1:0];
                state_d = S_RD;
              end
            end
            FUNC_FREE: begin
              if (BlkCntW'(start_blk) >= lim) begin
                done_d   = 1'b1;
                status_d = STAT_RANGE;
              end else begin
                ptr_d   = start_blk[BlkIdxW-1:BitIdxW];
                last_d  = start_blk[BlkIdxW-1:BitIdxW];
                lo_d    = start_blk[BitIdxW-1:0];
                hi_d    = start_blk[BitIdxW-1:0];
                state_d = S_RD;
              end
            end
            FUNC_RELEASE: begin
              if (lo_eff >= end_blk) begin
                done_d = 1'b1;
              end else begin
                ptr_d   = lo_eff[BlkIdxW-1:BitIdxW];
                last_d  = end_m1[BlkIdxW-1:BitIdxW];
                lo_d    = lo_eff[BitIdxW-1:0];
                hi_d    = end_m1[BitIdxW-1:0];
                state_d = S_RD;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        re      = 1'b1;
        state_d = S_MOD;
      end
      S_MOD: begin
        if (op_q == FUNC_ALLOC) begin
          if (avail != '0) begin
            we       = 1'b1;
            wdata    = rdata | (WordBits'(1) << hit_bit);
            baddr_d  = AddrW'({ptr_q, hit_bit, {BlockShift{1'b0}}});
            status_d = STAT_OK;
            done_d   = 1'b1;
            state_d  = S_IDLE;
          end else if (ptr_q == last_q) begin
            status_d = STAT_OOM;
            done_d   = 1'b1;
            state_d  = S_IDLE;
          end else begin
            ptr_d   = ptr_q + WordIdxW'(1);
            state_d = S_RD;
          end
        end else begin
          we    = 1'b1;
          wdata = rdata & ~range_mask;
          lo_d  = '0;
          if (ptr_q == last_q) begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_q + WordIdxW'(1);
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      ptr_q    <= '0;
      done_q   <= 1'b0;
      status_q <= STAT_OK;
      baddr_q  <= '0;
      total_q  <= '0;
      rsv_q    <= ReservedReset;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      done_q   <= done_d;
      status_q <= status_d;
      baddr_q  <= baddr_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TOTAL:    total_q <= cfg_wdata_i;
          CFG_RESERVED: rsv_q   <= cfg_wdata_i;
          default:      total_q <= total_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    last_q <= last_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
  end

  bpa_ram #(
    .Width (WordBits),
    .Depth (MapWords)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (ptr_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign block_addr_o = baddr_q;
  assign status_o     = status_q;

endmodule

`default_nettype wire
